[hw/rtl/tlb_page_table_translator_macros.svh]
// assertion macros for the tlb page table translator
// used by the top level, no other dependencies
`ifndef TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define TLBPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TLBPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tlbpt_pkg.sv]
// shared types and constants of the tlb page table translator
// no dependencies
`default_nettype none

package tlbpt_pkg;

  localparam int TLB_ENTRIES_DEF = 16;
  localparam int NUM_PAGES_DEF   = 256;
  localparam int PAGE_BYTES_DEF  = 256;

  // widest page / frame index over the supported table sizes
  localparam int PAGE_W_MAX = 12;

  typedef struct packed {
    logic [7:0] page_number;
    logic [7:0] page_offset;
  } req_item_t;

  typedef struct packed {
    logic [15:0] physical_address;
    logic        tlb_hit;
    logic        page_fault;
  } resp_item_t;

  // tlb fill request from the control logic
  typedef struct packed {
    logic                  en;
    logic [PAGE_W_MAX-1:0] page;
    logic [PAGE_W_MAX-1:0] frame;
  } tlb_fill_t;

  // tlb search result
  typedef struct packed {
    logic                  hit;
    logic [PAGE_W_MAX-1:0] frame;
  } tlb_match_t;

endpackage

`default_nettype wire

[hw/rtl/tlbpt_tlb.sv]
// fully associative tlb with fifo replacement
// depends on tlbpt_pkg
`default_nettype none

module tlbpt_tlb #(
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int PAGE_W      = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [PAGE_W-1:0]      lookup_page,
  input  tlbpt_pkg::tlb_fill_t   fill,
  output tlbpt_pkg::tlb_match_t  match
);

  localparam int IW = $clog2(TLB_ENTRIES);
  localparam int FW = tlbpt_pkg::PAGE_W_MAX;

  logic [TLB_ENTRIES-1:0] valid;
  logic [PAGE_W-1:0]      page_tag  [TLB_ENTRIES];
  logic [PAGE_W-1:0]      frame_tag [TLB_ENTRIES];
  logic [IW-1:0]          fill_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      fill_ptr <= '0;
    end else if (fill.en) begin
      valid[fill_ptr] <= 1'b1;
      if (fill_ptr == IW'(TLB_ENTRIES - 1)) begin
        fill_ptr <= '0;
      end else begin
        fill_ptr <= fill_ptr + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fill.en) begin
      page_tag[fill_ptr]  <= fill.page[PAGE_W-1:0];
      frame_tag[fill_ptr] <= fill.frame[PAGE_W-1:0];
    end
  end

  // descending scan so the lowest matching slot wins
  always_comb begin
    match.hit   = 1'b0;
    match.frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && (page_tag[i] == lookup_page)) begin
        match.hit   = 1'b1;
        match.frame = FW'(frame_tag[i]);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tlb_page_table_translator.sv]
// tlb page table translator: the result is registered at the end of the lookup state;
// a new item is accepted only in the idle state, so the block takes no new item until
// the last one's result is registered; the page table word is read in the accept cycle
// and the decision, tlb fill and page table write-back happen in the lookup state once
// the result slot is free. after reset the page table is swept clear, all NUM_PAGES
// entries (256 by default), with req_stall high; the tlb valid bits clear at once.
`default_nettype none
`include "tlb_page_table_translator_macros.svh"

module tlb_page_table_translator #(
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int NUM_PAGES   = tlbpt_pkg::NUM_PAGES_DEF,
  parameter int PAGE_BYTES  = tlbpt_pkg::PAGE_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  tlbpt_pkg::req_item_t   req,
  output logic                   resp_valid,
  input  logic                   resp_stall,
  output tlbpt_pkg::resp_item_t  resp
);

  localparam int PW       = $clog2(NUM_PAGES);
  localparam int OW       = $clog2(PAGE_BYTES);
  localparam int FW       = tlbpt_pkg::PAGE_W_MAX;
  localparam int IN_CODES = 2 ** $bits(req.page_number);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // constant tables that wrap page number and offset into range
  logic [PW-1:0] page_mod [IN_CODES];
  logic [OW-1:0] off_mod  [IN_CODES];

  for (genvar g = 0; g < IN_CODES; g++) begin : g_mod
    assign page_mod[g] = PW'(g % NUM_PAGES);
    assign off_mod[g]  = OW'(g % PAGE_BYTES);
  end

  // page table: mapped flag above the frame number
  logic [PW:0]   pt_mem [NUM_PAGES];
  logic [PW:0]   pt_rd;

  logic [PW-1:0] clr_cnt;
  logic [PW-1:0] page_q;
  logic [OW-1:0] off_q;
  logic [PW:0]   frame_cnt;

  logic          accept;
  logic          out_free;
  logic          finish;
  logic          hit;
  logic          mapped;
  logic          fault;
  logic [PW-1:0] page_idx;
  logic [PW-1:0] alloc_frame;
  logic [PW-1:0] frame_sel;
  logic [15:0]   phys;

  tlbpt_pkg::tlb_fill_t  fill;
  tlbpt_pkg::tlb_match_t match;

  // the tlb searches the latched page during the lookup cycle
  tlbpt_tlb #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_W      (PW)
  ) u_tlb (
    .clk         (clk),
    .rst         (rst),
    .lookup_page (page_q),
    .fill        (fill),
    .match       (match)
  );

  // handshake: new item only when idle, result slot frees on take
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !resp_valid || !resp_stall;
  assign finish    = (state == ST_LOOK) && out_free;

  assign page_idx  = page_mod[req.page_number];

  // decision for the item in lookup
  assign hit    = match.hit;
  assign mapped = pt_rd[PW];
  assign fault  = !hit && !mapped;

  // counter saturates at NUM_PAGES, which wraps to frame zero
  assign alloc_frame = (frame_cnt == (PW + 1)'(NUM_PAGES)) ? '0 : frame_cnt[PW-1:0];

  always_comb begin
    priority if (hit) begin
      frame_sel = match.frame[PW-1:0];
    end else if (mapped) begin
      frame_sel = pt_rd[PW-1:0];
    end else begin
      frame_sel = alloc_frame;
    end
  end

  assign phys = 16'((32'(frame_sel) * 32'(PAGE_BYTES)) + 32'(off_q));

  // fault fills the tlb slot under the fifo pointer
  assign fill.en    = finish && fault;
  assign fill.page  = FW'(page_q);
  assign fill.frame = FW'(alloc_frame);

  // state sequencing
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == PW'(NUM_PAGES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      frame_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + PW'(1);
      end
      // next free frame advances once per fault until it reaches NUM_PAGES
      if (fill.en && (frame_cnt != (PW + 1)'(NUM_PAGES))) begin
        frame_cnt <= frame_cnt + (PW + 1)'(1);
      end
    end
  end

  // page table memory: one write port, registered read in the accept cycle;
  // a fault write lands before the next item can be accepted
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      pt_mem[clr_cnt] <= '0;
    end else if (fill.en) begin
      pt_mem[page_q] <= {1'b1, alloc_frame};
    end
    if (accept) begin
      pt_rd <= pt_mem[page_idx];
    end
  end

  // latch the item for the lookup cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      page_q <= page_idx;
      off_q  <= off_mod[req.page_offset];
    end
  end

  // output register keeps the result while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (finish) begin
      resp_valid <= 1'b1;
    end else if (!resp_stall) begin
      resp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      resp.physical_address <= phys;
      resp.tlb_hit          <= hit;
      resp.page_fault       <= fault;
    end
  end

  // checks
  `TLBPT_ASSERT_NEXT(a_accept_starts_lookup, clk, rst, accept, state == ST_LOOK, "accepted item did not start a lookup")
  `TLBPT_ASSERT_NOW(a_hit_excludes_fault, clk, rst, resp_valid, !(resp.tlb_hit && resp.page_fault), "result shows both tlb hit and page fault")
  `TLBPT_ASSERT_NEXT(a_fault_fills_tlb, clk, rst, finish && fault, match.hit, "faulted page not found in tlb after fill")
  `TLBPT_ASSERT_NOW(a_clear_blocks_input, clk, rst, state == ST_CLEAR, req_stall && !resp_valid, "item moved during page table clear")

endmodule

`default_nettype wire
